FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication shorthand: antecedent must be followed by consequent next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int PIN_W           = 4;
	localparam int CNT_W           = 7;
	localparam int REL_W           = 6;
	localparam int EN_W            = 4;
	localparam int CFG_DATA_W      = 7;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CNT_W-1:0] CNT_MAX       = 7'd127;
	localparam logic [CNT_W-1:0] LONG_RST      = 7'd60;
	localparam logic [CNT_W-1:0] SHORT_RST     = 7'd2;
	localparam logic [REL_W-1:0] RELEASE_RST   = 6'd8;
	localparam logic [EN_W-1:0]  ENABLE_RST    = 4'hF;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SHORT = 2'd1,
		PH_LONG  = 2'd2,
		PH_HOLD  = 2'd3
	} phase_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ACK  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG    = 2'd0,
		CFG_SHORT   = 2'd1,
		CFG_RELEASE = 2'd2,
		CFG_ENABLE  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] short_ticks;
		logic [REL_W-1:0] release_ticks;
	} lane_cfg_t;

	typedef struct packed {
		logic step;
		op_t  op;
	} lane_cmd_t;

	typedef struct packed {
		logic short_ev;
		logic long_ev;
	} lane_flags_t;

endpackage

FILE: hw/rtl/bpc_lane.sv
`timescale 1ns / 1ps

module bpc_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpc_pkg::lane_cmd_t   cmd,
	input  bpc_pkg::lane_cfg_t   cfg,
	input  logic                 enable,
	input  logic                 pin_up,
	output bpc_pkg::lane_flags_t flags
);

	bpc_pkg::phase_t                ph_q, ph_d;
	logic [bpc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [bpc_pkg::CNT_W-1:0]      cnt_inc;

	assign cnt_inc = (cnt_q == bpc_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		ph_d  = ph_q;
		cnt_d = cnt_q;
		if (cmd.step && enable) begin
			unique case (cmd.op)
				bpc_pkg::OP_ACK: begin
					if ((ph_q == bpc_pkg::PH_SHORT || ph_q == bpc_pkg::PH_LONG) && pin_up) begin
						ph_d  = bpc_pkg::PH_HOLD;
						cnt_d = '0;
					end
				end
				bpc_pkg::OP_TICK: begin
					unique case (ph_q)
						bpc_pkg::PH_IDLE: begin
							if (!pin_up) begin
								if (cnt_inc >= cfg.long_ticks) begin
									ph_d  = bpc_pkg::PH_LONG;
									cnt_d = '0;
								end else begin
									cnt_d = cnt_inc;
								end
							end else if (cnt_q >= cfg.short_ticks) begin
								ph_d  = bpc_pkg::PH_SHORT;
								cnt_d = '0;
							end
						end
						bpc_pkg::PH_HOLD: begin
							if (pin_up) begin
								if (cnt_inc >= {1'b0, cfg.release_ticks}) begin
									ph_d  = bpc_pkg::PH_IDLE;
									cnt_d = '0;
								end else begin
									cnt_d = cnt_inc;
								end
							end
						end
						// latched phases wait for an acknowledge
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// flags show the phase the lane enters with this request
	always_comb begin
		flags.short_ev = (ph_d == bpc_pkg::PH_SHORT);
		flags.long_ev  = (ph_d == bpc_pkg::PH_LONG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= bpc_pkg::PH_IDLE;
			cnt_q <= '0;
		end else begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

FILE: hw/rtl/bpc_merge.sv
`timescale 1ns / 1ps

module bpc_merge #(
	parameter int LANES = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  bpc_pkg::lane_flags_t [LANES-1:0] flags,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         in_ready,
	output logic [bpc_pkg::PIN_W-1:0]    short_events,
	output logic [bpc_pkg::PIN_W-1:0]    long_events
);

	logic                      out_valid_q;
	logic [bpc_pkg::PIN_W-1:0] short_q, long_q;
	logic [bpc_pkg::PIN_W-1:0] short_d, long_d;

	always_comb begin
		short_d = '0;
		long_d  = '0;
		for (int i = 0; i < LANES; i++) begin
			short_d[i] = flags[i].short_ev;
			long_d[i]  = flags[i].long_ev;
		end
	end

	// a new request may enter when no result is held or the held result leaves in the same cycle
	assign in_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			short_q <= short_d;
			long_q  <= long_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign short_events = short_q;
	assign long_events  = long_q;

endmodule

FILE: hw/rtl/button_press_classifier.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        sink       in_valid/in_ready    operation, pin_levels
// out       source     out_valid/out_ready  short_events, long_events
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// One request per cycle while in_ready is high; its result is registered on accept.
// Enabled per-button lanes update their phase and count in the cycle of acceptance.
// in_ready drops only while a result is held and out_ready is low.
// Reset puts every lane in idle with a zero count and loads the register defaults.

module button_press_classifier #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [bpc_pkg::PIN_W-1:0]         pin_levels,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bpc_pkg::PIN_W-1:0]         short_events,
	output logic [bpc_pkg::PIN_W-1:0]         long_events,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// buttons past the pin field never change and are not reported
	localparam int LANES = (NUM_BUTTONS < bpc_pkg::PIN_W) ? NUM_BUTTONS : bpc_pkg::PIN_W;

	logic                              accept;
	bpc_pkg::lane_cmd_t                cmd;
	bpc_pkg::lane_cfg_t                cfg_q;
	logic [bpc_pkg::EN_W-1:0]          enable_q;
	bpc_pkg::lane_flags_t [LANES-1:0]  flags;

	assign accept   = in_valid && in_ready;
	assign cmd.step = accept;
	assign cmd.op   = bpc_pkg::op_t'(operation);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks    <= bpc_pkg::LONG_RST;
			cfg_q.short_ticks   <= bpc_pkg::SHORT_RST;
			cfg_q.release_ticks <= bpc_pkg::RELEASE_RST;
			enable_q            <= bpc_pkg::ENABLE_RST;
		end else if (cfg_we) begin
			unique case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::CFG_LONG:    cfg_q.long_ticks    <= cfg_data[bpc_pkg::CNT_W-1:0];
				bpc_pkg::CFG_SHORT:   cfg_q.short_ticks   <= cfg_data[bpc_pkg::CNT_W-1:0];
				bpc_pkg::CFG_RELEASE: cfg_q.release_ticks <= cfg_data[bpc_pkg::REL_W-1:0];
				bpc_pkg::CFG_ENABLE:  enable_q            <= cfg_data[bpc_pkg::EN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		bpc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.cfg    (cfg_q),
			.enable (enable_q[i]),
			.pin_up (pin_levels[i]),
			.flags  (flags[i])
		);
	end

	bpc_merge #(
		.LANES (LANES)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.flags        (flags),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.in_ready     (in_ready),
		.short_events (short_events),
		.long_events  (long_events)
	);

endmodule

FILE: hw/rtl/bpc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [bpc_pkg::PIN_W-1:0]      short_events,
	input logic [bpc_pkg::PIN_W-1:0]      long_events
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(short_events) && $stable(long_events), "result changed while stalled")
	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready, "input stalled with empty output")
	`ASSERT_NEXT(a_result_follows, clk, arst_n, in_valid && in_ready, out_valid, "accepted request produced no result")
	`ASSERT_CLK(a_one_kind, clk, arst_n, out_valid |-> ((short_events & long_events) == '0), "button reports short and long at once")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.short_events (short_events),
	.long_events  (long_events)
);
